>>> hw/rtl/tnfs_pkg.sv
`timescale 1ns / 1ps

package tnfs_pkg;

    localparam int FREQ_BITS        = 32;
    localparam int CFG_BITS         = 5;
    localparam int MAX_TOP_DEFAULT  = 16;
    localparam int KEY_BITS_DEFAULT = 62;

    localparam logic [CFG_BITS-1:0] TOP_COUNT_RESET = CFG_BITS'(16);

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic                 ins;   // insert the offered pair
        logic                 pop;   // shift the list one place towards the head
        logic [FREQ_BITS-1:0] freq;  // frequency of the offered pair
    } cell_ctrl_t;

endpackage

>>> hw/rtl/tnfs_cell.sv
`timescale 1ns / 1ps

module tnfs_cell #(
    parameter int KEY_BITS = tnfs_pkg::KEY_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tnfs_pkg::cell_ctrl_t           ctrl,
    input  logic [KEY_BITS-1:0]            new_key,
    input  logic                           in_range,
    input  logic                           prev_ge,
    input  logic                           prev_valid,
    input  logic [KEY_BITS-1:0]            prev_key,
    input  logic [tnfs_pkg::FREQ_BITS-1:0] prev_freq,
    input  logic                           next_valid,
    input  logic [KEY_BITS-1:0]            next_key,
    input  logic [tnfs_pkg::FREQ_BITS-1:0] next_freq,
    output logic                           ge,
    output logic                           valid,
    output logic [KEY_BITS-1:0]            key,
    output logic [tnfs_pkg::FREQ_BITS-1:0] freq
);

    logic                           valid_reg, valid_next;
    logic [KEY_BITS-1:0]            key_reg, key_next;
    logic [tnfs_pkg::FREQ_BITS-1:0] freq_reg, freq_next;

    // equal frequency stays ahead of the newcomer
    assign ge = valid_reg && (freq_reg >= ctrl.freq);

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        freq_next  = freq_reg;
        if (ctrl.ins) begin
            if (!in_range) begin
                valid_next = 1'b0;
            end else if (!ge) begin
                if (prev_ge) begin
                    valid_next = 1'b1;
                    key_next   = new_key;
                    freq_next  = ctrl.freq;
                end else begin
                    valid_next = prev_valid;
                    key_next   = prev_key;
                    freq_next  = prev_freq;
                end
            end
        end else if (ctrl.pop) begin
            valid_next = next_valid;
            key_next   = next_key;
            freq_next  = next_freq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg  <= key_next;
        freq_reg <= freq_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign freq  = freq_reg;

endmodule

>>> hw/rtl/top_n_frequency_selector.sv
`timescale 1ns / 1ps
// A pair enters the sorted cell chain at the edge it is accepted; the first result
// is valid in the cycle after the last pair has been accepted.
// One pair per cycle while collecting; the chain compares all cells in parallel.
// After a last pair, the kept list drains one result per cycle while m_tready is high, from the head cell;
// no input is taken until the cycle after the final result has been transferred.
// Reset (synchronous, aresetn low): chain emptied, top_count back to 16.

module top_n_frequency_selector #(
    parameter int  MAX_TOP  = tnfs_pkg::MAX_TOP_DEFAULT,
    parameter int  KEY_BITS = tnfs_pkg::KEY_BITS_DEFAULT,
    localparam int TDATA_W  = ((KEY_BITS + tnfs_pkg::FREQ_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tnfs_pkg::CFG_BITS-1:0] cfg_data,   // top_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [TDATA_W-1:0]            s_tdata,    // kmer_key, frequency, zero pad
    input  logic                          s_tlast,    // last_pair
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDATA_W-1:0]            m_tdata,    // top_key, top_frequency, zero pad
    output logic                          m_tlast     // final_entry
);

    localparam int SLOTS   = MAX_TOP + 2;

    logic [tnfs_pkg::CFG_BITS-1:0] top_count_reg;
    logic                          drain_reg, drain_next;
    tnfs_pkg::cell_ctrl_t          ctrl;

    // slot 0 is the head sentinel, slot i+1 is cell i, the last slot the tail sentinel
    logic                           ge_s    [SLOTS];
    logic                           valid_s [SLOTS];
    logic [KEY_BITS-1:0]            key_s   [SLOTS];
    logic [tnfs_pkg::FREQ_BITS-1:0] freq_s  [SLOTS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_count_reg <= tnfs_pkg::TOP_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            top_count_reg <= cfg_data;
        end
    end

    assign s_tready  = !drain_reg;
    assign m_tvalid  = drain_reg && valid_s[1];
    assign ctrl.ins  = s_tvalid && s_tready;
    assign ctrl.pop  = m_tvalid && m_tready;
    assign ctrl.freq = s_tdata[KEY_BITS +: tnfs_pkg::FREQ_BITS];

    always_comb begin
        drain_next = drain_reg;
        if (ctrl.ins && s_tlast) begin
            drain_next = 1'b1;
        end else if (ctrl.pop && !valid_s[2]) begin
            drain_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_reg <= 1'b0;
        end else begin
            drain_reg <= drain_next;
        end
    end

    assign ge_s[0]          = 1'b1;
    assign valid_s[0]       = 1'b0;
    assign key_s[0]         = '0;
    assign freq_s[0]        = '0;
    assign ge_s[SLOTS-1]    = 1'b0;
    assign valid_s[SLOTS-1] = 1'b0;
    assign key_s[SLOTS-1]   = '0;
    assign freq_s[SLOTS-1]  = '0;

    for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
        logic in_range;

        // a top_count of zero keeps one entry
        assign in_range = (i == 0) ||
                          ({{(32 - tnfs_pkg::CFG_BITS){1'b0}}, top_count_reg} > 32'(i));

        tnfs_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_key    (s_tdata[KEY_BITS-1:0]),
            .in_range   (in_range),
            .prev_ge    (ge_s[i]),
            .prev_valid (valid_s[i]),
            .prev_key   (key_s[i]),
            .prev_freq  (freq_s[i]),
            .next_valid (valid_s[i+2]),
            .next_key   (key_s[i+2]),
            .next_freq  (freq_s[i+2]),
            .ge         (ge_s[i+1]),
            .valid      (valid_s[i+1]),
            .key        (key_s[i+1]),
            .freq       (freq_s[i+1])
        );
    end

    always_comb begin
        m_tdata                                   = '0;
        m_tdata[KEY_BITS-1:0]                     = key_s[1];
        m_tdata[KEY_BITS +: tnfs_pkg::FREQ_BITS]  = freq_s[1];
    end

    assign m_tlast = !valid_s[2];

endmodule

>>> hw/rtl/tnfs_checker.sv
`timescale 1ns / 1ps

module tnfs_checker #(
    parameter int TDATA_W = 96
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    // collecting and draining never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while results pending");

    a_drain_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last pair");

    a_drain_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("list ended without final entry");

    a_drain_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("block not idle after final transfer");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind top_n_frequency_selector tnfs_checker #(
    .TDATA_W (TDATA_W)
) u_tnfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int KEY_W       = tnfs_pkg::KEY_BITS_DEFAULT;
    localparam int FREQ_W      = tnfs_pkg::FREQ_BITS;
    localparam int MAX_TOP     = tnfs_pkg::MAX_TOP_DEFAULT;
    localparam int CFG_BITS    = tnfs_pkg::CFG_BITS;
    localparam logic [CFG_BITS-1:0] TOP_COUNT_RESET = tnfs_pkg::TOP_COUNT_RESET;
    localparam int DATA_W      = ((KEY_W + FREQ_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [FREQ_W-1:0] freq;
        logic              final_entry;
    } ranked_t;

    class top_list_tracker;
        logic [KEY_W-1:0]    kept_key[MAX_TOP];
        logic [FREQ_W-1:0]   kept_freq[MAX_TOP];
        int unsigned         held;
        logic [CFG_BITS-1:0] top_count;
        ranked_t             ranked_due[$];
        int unsigned         errors;

        function new();
            held      = 0;
            top_count = TOP_COUNT_RESET;
            errors    = 0;
        endfunction

        function void set_top_count(logic [CFG_BITS-1:0] v);
            top_count = v;
        endfunction

        function int unsigned limit();
            if (top_count == 0)
                return 1;
            if (top_count > MAX_TOP)
                return MAX_TOP;
            return int'(top_count);
        endfunction

        function void place(int unsigned pos, int unsigned len,
                            logic [KEY_W-1:0] key, logic [FREQ_W-1:0] freq);
            for (int unsigned i = len; i > pos; i--) begin
                kept_key[i]  = kept_key[i-1];
                kept_freq[i] = kept_freq[i-1];
            end
            kept_key[pos]  = key;
            kept_freq[pos] = freq;
        endfunction

        // equal frequency: later arrival sorts after, and goes first on eviction
        function void offer_pair(logic [KEY_W-1:0] key, logic [FREQ_W-1:0] freq, logic last);
            int unsigned lim;
            int unsigned pos;
            ranked_t     r;
            lim = limit();
            if (held > lim)
                held = lim;
            pos = 0;
            while (pos < held && kept_freq[pos] >= freq)
                pos++;
            if (held < lim) begin
                place(pos, held, key, freq);
                held++;
            end else if (freq > kept_freq[lim-1]) begin
                place(pos, lim - 1, key, freq);
            end
            if (last) begin
                for (int unsigned i = 0; i < held; i++) begin
                    r.key         = kept_key[i];
                    r.freq        = kept_freq[i];
                    r.final_entry = (i + 1 == held);
                    ranked_due.push_back(r);
                end
                held = 0;
            end
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task take_ranked(logic [KEY_W-1:0] key, logic [FREQ_W-1:0] freq, logic fin);
            ranked_t e;
            if (ranked_due.size() == 0) begin
                report($sformatf("unexpected result key %h freq %0d", key, freq));
                return;
            end
            e = ranked_due.pop_front();
            if (key !== e.key)
                report($sformatf("top_key %h, want %h", key, e.key));
            if (freq !== e.freq)
                report($sformatf("top_frequency %0d, want %0d", freq, e.freq));
            if (fin !== e.final_entry)
                report($sformatf("final_entry %b, want %b", fin, e.final_entry));
        endtask
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_BITS-1:0] cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata   = '0;   // kmer_key, frequency, zero pad
    logic                s_tlast   = 1'b0; // last_pair
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [DATA_W-1:0]   m_tdata;          // top_key, top_frequency, zero pad
    logic                m_tlast;          // final_entry

    top_list_tracker tracker;
    int unsigned     burst_left  = 0;
    int unsigned     idle_cycles = 0;
    int unsigned     rx_cycle    = 0;
    int unsigned     rx_mode     = 0;
    int unsigned     hold_left   = 0;
    bit              hold_want   = 1'b0;
    bit              hold_taken  = 1'b0;

    top_n_frequency_selector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // transfer monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn && tracker != null) begin
            if (cfg_valid && cfg_ready)
                tracker.set_top_count(cfg_data);
            if (s_tvalid && s_tready)
                tracker.offer_pair(s_tdata[KEY_W-1:0], s_tdata[KEY_W+FREQ_W-1:KEY_W], s_tlast);
            if (m_tvalid && m_tready)
                tracker.take_ranked(m_tdata[KEY_W-1:0], m_tdata[KEY_W+FREQ_W-1:KEY_W], m_tlast);
        end
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: four stall patterns picked at random, plus one long hold-off
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_want && !hold_taken && m_tvalid && s_tvalid) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_cycle % 3 == 0);
                default: m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return KEY_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [FREQ_W-1:0] rand_freq(int unsigned mode);
        if (mode == 0)
            return FREQ_W'($urandom_range(0, 15));
        if (mode == 1)
            return FREQ_W'($urandom);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return 32'hFFFF_FFFE;
            3: return 32'd1;
            default: return FREQ_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_top();
        case ($urandom_range(0, 6))
            0: return CFG_BITS'(0);
            1: return CFG_BITS'(1);
            2: return CFG_BITS'(2);
            3: return CFG_BITS'(16);
            4: return CFG_BITS'(31);
            default: return CFG_BITS'($urandom_range(0, 31));
        endcase
    endfunction

    task automatic send_pair(input logic [KEY_W-1:0] key, input logic [FREQ_W-1:0] freq,
                             input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'({freq, key});
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (tracker.ranked_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_top(input logic [CFG_BITS-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned n_items;
        int unsigned len;
        int unsigned fmode;
        int unsigned cut_at;
        int unsigned r;
        tracker = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset count of 16; extremes and a three-way tie
        send_pair('0, '0, 1'b0);
        send_pair('1, '1, 1'b0);
        send_pair(rand_key(), 32'd5, 1'b0);
        send_pair(rand_key(), 32'd5, 1'b0);
        send_pair(rand_key(), 32'd5, 1'b1);

        // keep one; an equal late pair must not evict
        write_top(CFG_BITS'(1));
        send_pair(rand_key(), 32'd10, 1'b0);
        send_pair(rand_key(), 32'd20, 1'b0);
        send_pair(rand_key(), 32'd20, 1'b0);
        send_pair(rand_key(), 32'd5, 1'b0);
        send_pair(rand_key(), 32'd20, 1'b1);

        // zero acts as one, above 16 acts as 16
        write_top(CFG_BITS'(0));
        send_pair(rand_key(), rand_freq(1), 1'b1);
        write_top(CFG_BITS'(31));
        send_pair(rand_key(), rand_freq(0), 1'b0);
        send_pair(rand_key(), rand_freq(0), 1'b0);
        send_pair(rand_key(), rand_freq(0), 1'b1);

        // count lowered mid-set drops the smallest entries
        write_top(CFG_BITS'(3));
        send_pair(rand_key(), 32'd7, 1'b0);
        send_pair(rand_key(), 32'd9, 1'b0);
        send_pair(rand_key(), 32'd3, 1'b0);
        send_pair(rand_key(), 32'd8, 1'b0);
        write_top(CFG_BITS'(2));
        send_pair(rand_key(), 32'd8, 1'b1);

        hold_want = 1'b1;
        n_items   = 0;
        while (n_items < 110) begin
            if ($urandom_range(0, 2) == 0)
                write_top(pick_top());
            r = $urandom_range(0, 9);
            if (r < 6)
                len = $urandom_range(1, 8);
            else if (r < 9)
                len = $urandom_range(9, 20);
            else
                len = $urandom_range(17, 24);
            fmode  = $urandom_range(0, 2);
            cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : 0;
            for (int unsigned i = 0; i < len; i++) begin
                if (cut_at != 0 && i == cut_at)
                    write_top(CFG_BITS'($urandom_range(0, int'(tracker.top_count))));
                send_pair(rand_key(), rand_freq(fmode), i == len - 1);
                n_items++;
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0 && tracker.ranked_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
